@@ rtl/pfx_pkg.sv @@
// Package for the prefix code bit packer.
// Holds field widths, command codes, the control struct and the length cap helper.
// No dependencies.
package pfx_pkg;

  localparam int BYTE_W               = 8;
  localparam int SYM_W                = 8;
  localparam int TABLE_DEPTH          = 256;
  localparam int CODE_FIELD_W         = 32;
  localparam int LEN_FIELD_W          = 6;
  localparam int DEFAULT_MAX_CODE_LEN = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic go;
    logic flush;
  } job_ctl_t;

  function automatic int len_cap(input int max_len);
    return (max_len < CODE_FIELD_W) ? max_len : CODE_FIELD_W;
  endfunction

endpackage

@@ rtl/pfx_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pfx_bit_packer.sv @@
// Bit-serial packer: shifts one code bit per cycle into the byte accumulator unless the output stalls.
// Holds the output byte register and handles flush. Depends on pfx_pkg.
module pfx_bit_packer import pfx_pkg::*; #(
  parameter int CODE_W = 32,
  parameter int LEN_W  = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  job_ctl_t          ctl,
  input  logic [CODE_W-1:0] code,
  input  logic [LEN_W-1:0]  len,
  output logic              busy,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last,
  output logic              byte_valid,
  input  logic              byte_ready
);

  localparam int CNT_W = $clog2(BYTE_W);

  typedef enum logic [1:0] {
    P_IDLE,
    P_SHIFT,
    P_FLUSH
  } pstate_t;

  pstate_t           state;
  logic [CODE_W-1:0] sr;
  logic [LEN_W-1:0]  rem;
  logic [BYTE_W-1:0] acc;
  logic [CNT_W-1:0]  cnt;

  logic              slot_free;
  logic              full;
  logic              step;
  logic              emit;
  logic [BYTE_W-1:0] acc_shift;
  logic [LEN_W-1:0]  align;
  logic              last_next;
  logic [CNT_W:0]    pad;

  always_comb begin
    slot_free = !byte_valid || byte_ready;
    full      = (cnt == CNT_W'(BYTE_W - 1));
    step      = (state == P_SHIFT) && (!full || slot_free);
    emit      = (step && full) || ((state == P_FLUSH) && slot_free && (cnt != '0));
    acc_shift = {acc[BYTE_W-2:0], sr[CODE_W-1]};
    align     = LEN_W'(CODE_W) - len;
    last_next = ((LEN_W + 4)'(rem) <= (LEN_W + 4)'(BYTE_W));
    pad       = (CNT_W + 1)'(BYTE_W) - {1'b0, cnt};
    busy      = (state != P_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= P_IDLE;
      acc        <= '0;
      cnt        <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (emit) begin
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
      unique case (state)
        P_IDLE: begin
          if (ctl.go) begin
            if (ctl.flush) begin
              state <= P_FLUSH;
            end else if (len != '0) begin
              sr    <= code << align;
              rem   <= len;
              state <= P_SHIFT;
            end
          end
        end
        P_SHIFT: begin
          if (step) begin
            sr  <= sr << 1;
            rem <= rem - LEN_W'(1);
            if (full) begin
              out_byte <= acc_shift;
              last     <= last_next;
              acc      <= '0;
              cnt      <= '0;
            end else begin
              acc <= acc_shift;
              cnt <= cnt + CNT_W'(1);
            end
            if (rem == LEN_W'(1)) begin
              state <= P_IDLE;
            end
          end
        end
        P_FLUSH: begin
          if (slot_free) begin
            if (cnt != '0) begin
              out_byte <= acc << pad;
              last     <= 1'b1;
            end
            acc   <= '0;
            cnt   <= '0;
            state <= P_IDLE;
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A completed byte always lands in the output register.
  a_byte_emitted: assert property (@(posedge clk) disable iff (rst)
    step && full |=> byte_valid)
    else $error("completed byte was not presented");

  // A flush that finds the output slot free leaves the accumulator empty.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == P_FLUSH) && slot_free |=> (cnt == '0) && (state == P_IDLE))
    else $error("flush did not clear the accumulator");

  // A byte that cannot be placed holds the shifter in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == P_SHIFT) && full && !slot_free |=> $stable(rem) && $stable(acc))
    else $error("shifter advanced while the output was blocked");
`endif

endmodule

@@ rtl/pfx_code_table.sv @@
// Code table: a RAM of codes and lengths plus one valid bit per entry.
// An entry never loaded reads as length zero. Depends on pfx_pkg and pfx_ram.
module pfx_code_table import pfx_pkg::*; #(
  parameter int CODE_W = 32,
  parameter int LEN_W  = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [SYM_W-1:0]  waddr,
  input  logic [CODE_W-1:0] wcode,
  input  logic [LEN_W-1:0]  wlen,
  input  logic              re,
  input  logic [SYM_W-1:0]  raddr,
  output logic [CODE_W-1:0] rcode,
  output logic [LEN_W-1:0]  rlen
);

  logic [TABLE_DEPTH-1:0]    valid;
  logic                      hit;
  logic [CODE_W+LEN_W-1:0]   rdata;

  pfx_ram #(
    .WIDTH(CODE_W + LEN_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({wcode, wlen}),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        hit <= valid[raddr];
      end
    end
  end

  always_comb begin
    rcode = rdata[CODE_W+LEN_W-1:LEN_W];
    rlen  = hit ? rdata[LEN_W-1:0] : '0;
  end

`ifndef NO_ASSERTIONS
  // A loaded entry is marked valid from the next cycle on.
  a_load_marks_valid: assert property (@(posedge clk) disable iff (rst)
    we |=> valid[$past(waddr)])
    else $error("loaded entry not marked valid");
`endif

endmodule

@@ rtl/prefix_code_bit_packer.sv @@
// Top level of the prefix code bit packer: input control, code table and packer.
// Depends on pfx_pkg, pfx_code_table and pfx_bit_packer.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  item    | item_valid / item_ready   | cmd, symbol, code_bits, code_len
//  byte    | byte_valid / byte_ready   | out_byte, last
//
// A symbol transaction does one table read, then shifts its code one bit per cycle through
// the serial shifter, then returns to idle. A stalled byte channel holds the shifter only
// when a completed byte finds the output register full, and holds a flush until that
// register is free. Reset is synchronous and clears the table valid bits, the accumulator
// and all control state.
module prefix_code_bit_packer import pfx_pkg::*; #(
  parameter int MAX_CODE_LEN = DEFAULT_MAX_CODE_LEN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [1:0]              cmd,
  input  logic [SYM_W-1:0]        symbol,
  input  logic [CODE_FIELD_W-1:0] code_bits,
  input  logic [LEN_FIELD_W-1:0]  code_len,
  output logic                    byte_valid,
  input  logic                    byte_ready,
  output logic [BYTE_W-1:0]       out_byte,
  output logic                    last
);

  localparam int CODE_W = len_cap(MAX_CODE_LEN);
  localparam int LEN_W  = $clog2(CODE_W + 1);

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOOKUP,
    T_FLUSH,
    T_WAIT
  } tstate_t;

  tstate_t           state;
  logic              accept;
  logic              load;
  logic [LEN_W-1:0]  len_capped;
  logic [CODE_W-1:0] code_masked;
  logic [CODE_W-1:0] rcode;
  logic [LEN_W-1:0]  rlen;
  logic              busy;
  job_ctl_t          ctl;

  always_comb begin
    item_ready  = (state == T_IDLE);
    accept      = item_valid && item_ready;
    load        = accept && (cmd_t'(cmd) == CMD_LOAD);
    len_capped  = (code_len > LEN_FIELD_W'(CODE_W)) ? LEN_W'(CODE_W)
                                                    : code_len[LEN_W-1:0];
    code_masked = code_bits[CODE_W-1:0] & ~({CODE_W{1'b1}} << len_capped);
    ctl.go      = (state == T_LOOKUP) || (state == T_FLUSH);
    ctl.flush   = (state == T_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            case (cmd_t'(cmd))
              CMD_ENCODE: state <= T_LOOKUP;
              CMD_FLUSH:  state <= T_FLUSH;
              default:    state <= T_IDLE;
            endcase
          end
        end
        T_LOOKUP: state <= T_WAIT;
        T_FLUSH:  state <= T_WAIT;
        T_WAIT: begin
          if (!busy) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  pfx_code_table #(
    .CODE_W(CODE_W),
    .LEN_W (LEN_W)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .we   (load),
    .waddr(symbol),
    .wcode(code_masked),
    .wlen (len_capped),
    .re   (accept),
    .raddr(symbol),
    .rcode(rcode),
    .rlen (rlen)
  );

  pfx_bit_packer #(
    .CODE_W(CODE_W),
    .LEN_W (LEN_W)
  ) u_packer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .code      (rcode),
    .len       (rlen),
    .busy      (busy),
    .out_byte  (out_byte),
    .last      (last),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready)
  );

`ifndef NO_ASSERTIONS
  // The block only takes a new transaction once the packer has finished.
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> !busy)
    else $error("input accepted while the packer is busy");

  // An encode transaction moves through T_LOOKUP, which starts the packer, and then T_WAIT.
  a_encode_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd_t'(cmd) == CMD_ENCODE) |=> (state == T_LOOKUP) ##1 (state == T_WAIT))
    else $error("encode did not start the packer");
`endif

endmodule

@@ test/tb_prefix_code_bit_packer.sv @@
// Testbench for prefix_code_bit_packer: directed table rows followed by random items.
// Every accepted output byte is checked against the row's expected bytes or a local model.
// Depends on pfx_pkg and the prefix_code_bit_packer RTL.
module tb_prefix_code_bit_packer;
  import pfx_pkg::*;

  localparam int LEN_LIMIT = (DEFAULT_MAX_CODE_LEN < CODE_FIELD_W) ?
                             DEFAULT_MAX_CODE_LEN : CODE_FIELD_W;
  localparam int PLAN_LEN  = 24;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
  } byte_exp_t;

  typedef struct packed {
    cmd_t                    op;
    logic [SYM_W-1:0]        sym;
    logic [CODE_FIELD_W-1:0] bits;
    logic [LEN_FIELD_W-1:0]  len;
    logic                    typed;
    logic [2:0]              n;
    logic [31:0]             bytes;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  logic [1:0]              cmd;
  logic [SYM_W-1:0]        symbol;
  logic [CODE_FIELD_W-1:0] code_bits;
  logic [LEN_FIELD_W-1:0]  code_len;
  logic                    byte_valid;
  logic                    byte_ready;
  logic [BYTE_W-1:0]       out_byte;
  logic                    last;

  logic [CODE_FIELD_W-1:0] code_mem [TABLE_DEPTH];
  int                      len_mem  [TABLE_DEPTH];
  logic [BYTE_W-1:0]       acc;
  int                      fill;
  logic [31:0]             pred_word;
  byte_exp_t               due_bytes [$];
  row_t                    plan [PLAN_LEN];
  int                      errors = 0;
  bit                      stall_mode = 1'b1;

  prefix_code_bit_packer uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .symbol     (symbol),
    .code_bits  (code_bits),
    .code_len   (code_len),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string what);
    if (errors < 40) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Updates the local table and packer state; returns the number of bytes in pred_word.
  function automatic int apply_item(input cmd_t op, input logic [SYM_W-1:0] sym,
                                    input logic [CODE_FIELD_W-1:0] bits,
                                    input logic [LEN_FIELD_W-1:0] len);
    int n;
    int eff;
    int i;
    logic [CODE_FIELD_W-1:0] word;
    n = 0;
    pred_word = '0;
    case (op)
      CMD_LOAD: begin
        eff = (int'(len) > LEN_LIMIT) ? LEN_LIMIT : int'(len);
        word = bits;
        if (eff < CODE_FIELD_W) begin
          word = word & ((32'd1 << eff) - 32'd1);
        end
        code_mem[sym] = word;
        len_mem[sym] = eff;
      end
      CMD_ENCODE: begin
        for (i = len_mem[sym]; i > 0; i--) begin
          acc = {acc[BYTE_W-2:0], code_mem[sym][i-1]};
          fill++;
          if (fill == BYTE_W) begin
            pred_word[31-8*n -: 8] = acc;
            n++;
            acc = '0;
            fill = 0;
          end
        end
      end
      CMD_FLUSH: begin
        if (fill > 0) begin
          pred_word[31:24] = acc << (BYTE_W - fill);
          n = 1;
        end
        acc = '0;
        fill = 0;
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  task automatic post_expected(input int n, input logic [31:0] bytes);
    byte_exp_t e;
    for (int k = 0; k < n; k++) begin
      e.data = bytes[31-8*k -: 8];
      e.fin = (k == n - 1);
      due_bytes.push_back(e);
    end
  endtask

  task automatic send_item(input cmd_t op, input logic [SYM_W-1:0] sym,
                           input logic [CODE_FIELD_W-1:0] bits,
                           input logic [LEN_FIELD_W-1:0] len);
    int gap;
    gap = stall_mode ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= op;
    symbol <= sym;
    code_bits <= bits;
    code_len <= len;
    @(negedge clk);
    while (!item_ready) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int gap;
    byte_ready <= 1'b0;
    forever begin
      gap = stall_mode ? pick_gap() : 0;
      if (gap > 0) begin
        byte_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    byte_exp_t want;
    if (!rst && byte_valid && byte_ready) begin
      if (due_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", out_byte, last));
      end else begin
        want = due_bytes.pop_front();
        if (out_byte !== want.data) begin
          report($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        end
        if (last !== want.fin) begin
          report($sformatf("last %0b, expected %0b", last, want.fin));
        end
      end
    end
  end

  initial begin
    int i;
    int n;
    int r;
    int k;
    int counted;
    cmd_t op;
    logic [SYM_W-1:0] sym;
    logic [CODE_FIELD_W-1:0] bits;
    logic [LEN_FIELD_W-1:0] len;

    rst <= 1'b1;
    item_valid <= 1'b0;
    cmd <= CMD_NONE;
    symbol <= '0;
    code_bits <= '0;
    code_len <= '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      code_mem[i] = '0;
      len_mem[i] = 0;
    end
    acc = '0;
    fill = 0;

    plan = '{
      '{CMD_ENCODE, 8'h00, 32'h00000000, 6'd0,  1'b1, 3'd0, 32'h00000000},
      '{CMD_FLUSH,  8'h00, 32'h00000000, 6'd0,  1'b1, 3'd0, 32'h00000000},
      '{CMD_NONE,   8'hff, 32'hffffffff, 6'd63, 1'b1, 3'd0, 32'h00000000},
      '{CMD_LOAD,   8'h00, 32'hffffffff, 6'd32, 1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h00, 32'h00000000, 6'd0,  1'b1, 3'd4, 32'hffffffff},
      '{CMD_LOAD,   8'hff, 32'h00000000, 6'd32, 1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'hff, 32'h00000000, 6'd0,  1'b1, 3'd4, 32'h00000000},
      '{CMD_LOAD,   8'h01, 32'hffffffff, 6'd1,  1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h01, 32'h00000000, 6'd0,  1'b1, 3'd0, 32'h00000000},
      '{CMD_FLUSH,  8'h00, 32'h00000000, 6'd0,  1'b1, 3'd1, 32'h80000000},
      '{CMD_LOAD,   8'h02, 32'ha5a5a5a5, 6'd63, 1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h02, 32'h00000000, 6'd0,  1'b1, 3'd4, 32'ha5a5a5a5},
      '{CMD_LOAD,   8'h03, 32'h00000005, 6'd3,  1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h03, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h03, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h03, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000},
      '{CMD_NONE,   8'h03, 32'h12345678, 6'd9,  1'b1, 3'd0, 32'h00000000},
      '{CMD_LOAD,   8'h04, 32'h0000ffff, 6'd0,  1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h04, 32'h00000000, 6'd0,  1'b1, 3'd0, 32'h00000000},
      '{CMD_FLUSH,  8'h00, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000},
      '{CMD_LOAD,   8'h05, 32'h000003ff, 6'd33, 1'b1, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h05, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000},
      '{CMD_ENCODE, 8'h02, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000},
      '{CMD_FLUSH,  8'h00, 32'h00000000, 6'd0,  1'b0, 3'd0, 32'h00000000}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_LEN; i++) begin
      send_item(plan[i].op, plan[i].sym, plan[i].bits, plan[i].len);
      n = apply_item(plan[i].op, plan[i].sym, plan[i].bits, plan[i].len);
      if (plan[i].typed) begin
        post_expected(plan[i].n, plan[i].bytes);
      end else begin
        post_expected(n, pred_word);
      end
    end

    counted = 0;
    while (counted < 120) begin
      if (counted % 25 == 0) begin
        stall_mode = ($urandom_range(0, 3) != 0);
      end
      if (counted == 75) begin
        item_valid <= 1'b0;
        @(posedge clk);
        while (due_bytes.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 22) begin
        op = CMD_LOAD;
      end else if (r < 82) begin
        op = CMD_ENCODE;
      end else if (r < 95) begin
        op = CMD_FLUSH;
      end else begin
        op = CMD_NONE;
      end
      sym = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(0, 15));
      bits = $urandom;
      k = $urandom_range(0, 9);
      if (k < 6) begin
        len = 6'($urandom_range(1, 12));
      end else if (k < 8) begin
        len = 6'($urandom_range(13, 32));
      end else if (k < 9) begin
        len = 6'($urandom_range(33, 63));
      end else begin
        len = '0;
      end
      send_item(op, sym, bits, len);
      n = apply_item(op, sym, bits, len);
      post_expected(n, pred_word);
      if (op != CMD_NONE) begin
        counted++;
      end
    end

    item_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ prefix_code_bit_packer.f @@
rtl/pfx_pkg.sv
rtl/pfx_ram.sv
rtl/pfx_bit_packer.sv
rtl/pfx_code_table.sv
rtl/prefix_code_bit_packer.sv
test/tb_prefix_code_bit_packer.sv
